/* design/rss_pkg.sv */
package rss_pkg;

	// Width of every configuration register and of the register index.
	localparam int CFG_W     = 16;
	localparam int CFG_IDX_W = 2;

	// Defaults for the top-level parameters.
	localparam int DEF_TIMER_BITS       = 16;
	localparam int DEF_SUNRISE_FRAMES   = 8;
	localparam int DEF_COLORED_PROFILES = 3;

	// Register reset values.
	localparam logic [CFG_W-1:0] RST_FLASH_MS   = 16'd200;
	localparam logic [CFG_W-1:0] RST_SUNRISE_MS = 16'd375;
	localparam logic [CFG_W-1:0] RST_MONITOR_MS = 16'd250;
	localparam logic [CFG_W-1:0] RST_NOHOST_MS  = 16'd5000;

	// Result queue.
	localparam int OQ_DEPTH = 4;
	localparam int OQ_PTR_W = $clog2(OQ_DEPTH);
	localparam int OQ_CNT_W = $clog2(OQ_DEPTH + 1);

	// Legal ranges of a shown color.
	localparam logic [8:0] HUE_MAX = 9'd359;
	localparam logic [6:0] PCT_MAX = 7'd100;

	typedef enum logic [2:0] {
		FUNC_TICK      = 3'd0,
		FUNC_ACTIVITY  = 3'd1,
		FUNC_PROFILE   = 3'd2,
		FUNC_RECONNECT = 3'd3,
		FUNC_INIT      = 3'd4
	} func_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FLASH   = 2'd0,
		REG_SUNRISE = 2'd1,
		REG_MONITOR = 2'd2,
		REG_NOHOST  = 2'd3
	} reg_idx_t;

	typedef enum logic [1:0] {
		MODE_NONE    = 2'd0,
		MODE_SUNRISE = 2'd1,
		MODE_BLINK   = 2'd2
	} mode_t;

	typedef struct packed {
		logic [8:0] hue;
		logic [6:0] sat;
		logic [6:0] bri;
	} hsb_t;

	typedef struct packed {
		logic [CFG_W-1:0] flash_ms;
		logic [CFG_W-1:0] sunrise_ms;
		logic [CFG_W-1:0] monitor_ms;
		logic [CFG_W-1:0] nohost_ms;
	} cfg_t;

	typedef struct packed {
		logic [2:0] func;
		logic       host_connected;
		logic [2:0] profile_index;
		logic       is_active;
		logic       glow_enabled;
	} evt_t;

	typedef struct packed {
		logic       led_on;
		logic [8:0] hue;
		logic [6:0] saturation;
		logic [6:0] brightness;
	} res_t;

	localparam hsb_t NOHOST_COLOR = '{hue: 9'd0, sat: 7'd100, bri: 7'd25};

	// Color of each profile slot; slots without a color of their own read as red.
	function automatic hsb_t profile_color(input logic [2:0] p);
		hsb_t c;
		unique case (p)
			3'd1:    c = '{hue: 9'd120, sat: 7'd100, bri: 7'd25};
			3'd2:    c = '{hue: 9'd240, sat: 7'd100, bri: 7'd25};
			default: c = NOHOST_COLOR;
		endcase
		return c;
	endfunction

	// Sunrise frames; every index past 6 shows the same final frame.
	function automatic hsb_t rise_color(input logic [3:0] i);
		hsb_t c;
		unique case (i)
			4'd0:    c = '{hue: 9'd300, sat: 7'd100, bri: 7'd20};
			4'd1:    c = '{hue: 9'd325, sat: 7'd100, bri: 7'd22};
			4'd2:    c = '{hue: 9'd350, sat: 7'd100, bri: 7'd24};
			4'd3:    c = '{hue: 9'd12,  sat: 7'd100, bri: 7'd25};
			4'd4:    c = '{hue: 9'd24,  sat: 7'd100, bri: 7'd27};
			4'd5:    c = '{hue: 9'd36,  sat: 7'd100, bri: 7'd28};
			4'd6:    c = '{hue: 9'd48,  sat: 7'd90,  bri: 7'd30};
			default: c = '{hue: 9'd24,  sat: 7'd55,  bri: 7'd25};
		endcase
		return c;
	endfunction

endpackage

/* design/rss_if.sv */
interface rss_evt_if;
	logic       valid;
	logic       ready;
	logic [2:0] func;
	logic       host_connected;
	logic [2:0] profile_index;
	logic       is_active;
	logic       glow_enabled;

	modport source (output valid, func, host_connected, profile_index, is_active,
		glow_enabled, input ready);
	modport sink (input valid, func, host_connected, profile_index, is_active,
		glow_enabled, output ready);
endinterface

interface rss_res_if;
	logic       valid;
	logic       ready;
	logic       led_on;
	logic [8:0] hue;
	logic [6:0] saturation;
	logic [6:0] brightness;

	modport source (output valid, led_on, hue, saturation, brightness, input ready);
	modport sink (input valid, led_on, hue, saturation, brightness, output ready);
endinterface

interface rss_cfg_if;
	import rss_pkg::*;
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [CFG_W-1:0]     data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

/* design/rss_cfg_regs.sv */
module rss_cfg_regs (
	input  logic          clk,
	input  logic          arst_n,
	rss_cfg_if.sink       cfg,
	output rss_pkg::cfg_t regs
);
	import rss_pkg::*;

	cfg_t regs_q;

	assign cfg.ready = 1'b1;
	assign regs      = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.flash_ms   <= RST_FLASH_MS;
			regs_q.sunrise_ms <= RST_SUNRISE_MS;
			regs_q.monitor_ms <= RST_MONITOR_MS;
			regs_q.nohost_ms  <= RST_NOHOST_MS;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_FLASH:   regs_q.flash_ms   <= cfg.data;
				REG_SUNRISE: regs_q.sunrise_ms <= cfg.data;
				REG_MONITOR: regs_q.monitor_ms <= cfg.data;
				REG_NOHOST:  regs_q.nohost_ms  <= cfg.data;
				default:     regs_q            <= regs_q;
			endcase
		end
	end

endmodule

/* design/rss_core.sv */
module rss_core #(
	parameter int TIMER_BITS       = rss_pkg::DEF_TIMER_BITS,
	parameter int SUNRISE_FRAMES   = rss_pkg::DEF_SUNRISE_FRAMES,
	parameter int COLORED_PROFILES = rss_pkg::DEF_COLORED_PROFILES
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          evt_take,
	input  rss_pkg::evt_t evt,
	input  rss_pkg::cfg_t cfg,
	output logic          busy,
	output logic          res_valid,
	output rss_pkg::res_t res
);
	import rss_pkg::*;

	localparam int IDX_W = $clog2(SUNRISE_FRAMES + 1);
	localparam int CMP_W = (TIMER_BITS > CFG_W) ? TIMER_BITS : CFG_W;

	// Input stage.
	logic evt_valid_s1;
	evt_t evt_s1;

	// Sequencer state.
	logic [2:0]            active_q, prev_q;
	logic                  was_q, idle_q, glow_q;
	mode_t                 mode_q;
	logic [2:0]            left_q;
	hsb_t                  bcol_q;
	logic [IDX_W-1:0]      idx_q;
	logic [TIMER_BITS-1:0] anim_q, mon_q, since_q;
	logic                  on_q;
	hsb_t                  col_q;

	logic [2:0]            n_active, n_prev;
	logic                  n_was, n_idle, n_glow;
	mode_t                 n_mode;
	logic [2:0]            n_left;
	hsb_t                  n_bcol;
	logic [IDX_W-1:0]      n_idx;
	logic [TIMER_BITS-1:0] n_anim, n_mon, n_since;
	logic                  n_on;
	hsb_t                  n_col;
	logic                  touched;

	logic       conn;
	logic [4:0] idx_ext;
	logic [4:0] idx_prev;
	hsb_t       active_color;

	function automatic logic [TIMER_BITS-1:0] tinc(input logic [TIMER_BITS-1:0] t);
		return (t == '1) ? t : t + 1'b1;
	endfunction

	function automatic logic reached(input logic [TIMER_BITS-1:0] t,
		input logic [CFG_W-1:0] per);
		return CMP_W'(t) >= CMP_W'(per);
	endfunction

	function automatic logic has_color(input logic [2:0] p);
		return 4'(p) < 4'(COLORED_PROFILES);
	endfunction

	function automatic hsb_t color_of(input logic [2:0] p);
		return has_color(p) ? profile_color(p) : NOHOST_COLOR;
	endfunction

	assign busy         = evt_valid_s1;
	assign conn         = evt_s1.host_connected;
	assign idx_ext      = 5'(idx_q);
	assign idx_prev     = idx_ext - 5'd1;
	assign active_color = color_of(active_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			evt_valid_s1 <= 1'b0;
		end else begin
			evt_valid_s1 <= evt_take;
		end
	end

	always_ff @(posedge clk) begin
		if (evt_take) begin
			evt_s1 <= evt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= '0;
			prev_q   <= '0;
			was_q    <= 1'b0;
			idle_q   <= 1'b0;
			glow_q   <= 1'b1;
			mode_q   <= MODE_NONE;
			left_q   <= '0;
			bcol_q   <= '0;
			idx_q    <= '0;
			anim_q   <= '0;
			mon_q    <= '0;
			since_q  <= '0;
			on_q     <= 1'b0;
			col_q    <= '0;
		end else begin
			active_q <= n_active;
			prev_q   <= n_prev;
			was_q    <= n_was;
			idle_q   <= n_idle;
			glow_q   <= n_glow;
			mode_q   <= n_mode;
			left_q   <= n_left;
			bcol_q   <= n_bcol;
			idx_q    <= n_idx;
			anim_q   <= n_anim;
			mon_q    <= n_mon;
			since_q  <= n_since;
			on_q     <= n_on;
			col_q    <= n_col;
		end
	end

	// Next state. Within one tick the animation step comes first and the
	// link check after it, so a burst started by the check wins.
	always_comb begin
		n_active = active_q;
		n_prev   = prev_q;
		n_was    = was_q;
		n_idle   = idle_q;
		n_glow   = glow_q;
		n_mode   = mode_q;
		n_left   = left_q;
		n_bcol   = bcol_q;
		n_idx    = idx_q;
		n_anim   = anim_q;
		n_mon    = mon_q;
		n_since  = since_q;
		n_on     = on_q;
		n_col    = col_q;
		touched  = 1'b0;
		if (evt_valid_s1) begin
			unique case (evt_s1.func)
				FUNC_TICK: begin
					n_since = tinc(since_q);
					if (mode_q != MODE_NONE) begin
						n_anim = tinc(anim_q);
						if (reached(n_anim, (mode_q == MODE_SUNRISE) ?
							cfg.sunrise_ms : cfg.flash_ms)) begin
							n_anim  = '0;
							touched = 1'b1;
							if (mode_q == MODE_SUNRISE) begin
								if (idx_q >= IDX_W'(SUNRISE_FRAMES)) begin
									n_mode = MODE_NONE;
									n_on   = conn;
									if (conn) begin
										n_col = active_color;
									end
								end else begin
									n_on  = 1'b1;
									n_col = rise_color(idx_ext[3:0]);
									n_idx = idx_q + 1'b1;
								end
							end else if (left_q == 3'd0) begin
								n_mode = MODE_NONE;
								n_on   = !idle_q && conn;
								if (!idle_q && conn) begin
									n_col = active_color;
								end
							end else begin
								n_on = !left_q[0];
								if (!left_q[0]) begin
									n_col = bcol_q;
								end
								n_left = left_q - 3'd1;
							end
						end
					end
					n_mon = tinc(mon_q);
					if (reached(n_mon, cfg.monitor_ms)) begin
						n_mon = '0;
						if (!idle_q) begin
							if (conn && !was_q) begin
								n_mode  = MODE_BLINK;
								n_bcol  = active_color;
								n_left  = 3'd5;
								n_on    = 1'b1;
								n_col   = active_color;
								n_anim  = '0;
								touched = 1'b1;
							end else if (!conn && n_left == 3'd0 &&
								reached(n_since, cfg.nohost_ms)) begin
								n_since = '0;
								n_mode  = MODE_BLINK;
								n_bcol  = NOHOST_COLOR;
								n_left  = 3'd3;
								n_on    = 1'b1;
								n_col   = NOHOST_COLOR;
								n_anim  = '0;
								touched = 1'b1;
							end
							n_was = conn;
						end
					end
				end
				FUNC_ACTIVITY: begin
					if (evt_s1.is_active) begin
						if (idle_q) begin
							n_idle  = 1'b0;
							n_since = '0;
							if (glow_q) begin
								n_on    = 1'b1;
								touched = 1'b1;
							end
						end
					end else if (!idle_q) begin
						n_glow  = evt_s1.glow_enabled;
						n_idle  = 1'b1;
						n_mode  = MODE_NONE;
						n_on    = 1'b0;
						touched = 1'b1;
					end
				end
				FUNC_PROFILE: begin
					n_active = evt_s1.profile_index;
					n_prev   = evt_s1.profile_index;
					n_was    = conn;
					if (has_color(evt_s1.profile_index) &&
						(conn || evt_s1.profile_index != prev_q)) begin
						n_mode  = MODE_BLINK;
						n_bcol  = profile_color(evt_s1.profile_index);
						n_left  = conn ? 3'd5 : 3'd3;
						n_on    = 1'b1;
						n_col   = profile_color(evt_s1.profile_index);
						n_anim  = '0;
						touched = 1'b1;
					end
				end
				FUNC_RECONNECT: begin
					touched = 1'b1;
					if (idx_q != '0 && idx_q <= IDX_W'(SUNRISE_FRAMES)) begin
						n_on  = 1'b1;
						n_col = rise_color(idx_prev[3:0]);
					end else if (!idle_q && conn) begin
						n_on  = 1'b1;
						n_col = active_color;
					end else begin
						n_on = 1'b0;
					end
				end
				FUNC_INIT: begin
					n_active = evt_s1.profile_index;
					n_prev   = evt_s1.profile_index;
					n_was    = conn;
					n_since  = '0;
					n_mode   = MODE_SUNRISE;
					n_idx    = IDX_W'(1);
					n_anim   = '0;
					n_mon    = '0;
					n_on     = 1'b1;
					n_col    = rise_color(4'd0);
					touched  = 1'b1;
				end
				default: begin
					touched = 1'b0;
				end
			endcase
		end
	end

	// Result of the item in the input stage: the final LED state, color
	// forced to zero while the LEDs are off.
	always_comb begin
		res_valid      = evt_valid_s1 && touched;
		res.led_on     = n_on;
		res.hue        = n_on ? n_col.hue : '0;
		res.saturation = n_on ? n_col.sat : '0;
		res.brightness = n_on ? n_col.bri : '0;
	end

endmodule

/* design/rss_out_fifo.sv */
module rss_out_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  rss_pkg::res_t push_data,
	input  logic          reserve,
	output logic          room,
	rss_res_if.source     res
);
	import rss_pkg::*;

	res_t                data_q [OQ_DEPTH];
	logic [OQ_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [OQ_CNT_W-1:0] cnt_q;
	logic                pop;
	res_t                head;

	// A new beat is taken only if the queue can still hold it after the
	// beat already in the input stage.
	assign room = (cnt_q + OQ_CNT_W'(reserve)) < OQ_CNT_W'(OQ_DEPTH);

	assign pop            = res.valid && res.ready;
	assign head           = data_q[rd_ptr_q];
	assign res.valid      = cnt_q != '0;
	assign res.led_on     = head.led_on;
	assign res.hue        = head.hue;
	assign res.saturation = head.saturation;
	assign res.brightness = head.brightness;

	always_ff @(posedge clk) begin
		if (push) begin
			data_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			priority if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end else begin
				cnt_q <= cnt_q;
			end
		end
	end

endmodule

/* design/rgb_status_sequencer.sv */
// Channel  Direction  Payload                                              Beat when
// evt      sink       func, host_connected, profile_index, is_active,       valid && ready
//                     glow_enabled
// res      source     led_on, hue, saturation, brightness                  valid && ready
// cfg      sink       index (register number), data (16-bit value)         valid && ready
//
// One event beat can be taken every cycle while evt.ready is high; the event is registered into
// the input stage, where the state update and the LED result are computed, and its result beat
// is registered into the result queue before it can leave on res.
// evt.ready drops once the four-beat result queue and the input stage could not absorb
// another result, so a stalled res side stops intake and no result is lost.
// arst_n resets the sequencer state and queue pointers and loads the register reset values; cfg.ready is always high.
module rgb_status_sequencer #(
	parameter int TIMER_BITS       = rss_pkg::DEF_TIMER_BITS,
	parameter int SUNRISE_FRAMES   = rss_pkg::DEF_SUNRISE_FRAMES,
	parameter int COLORED_PROFILES = rss_pkg::DEF_COLORED_PROFILES
) (
	input  logic      clk,
	input  logic      arst_n,
	rss_evt_if.sink   evt,
	rss_res_if.source res,
	rss_cfg_if.sink   cfg
);
	import rss_pkg::*;

	cfg_t regs;
	evt_t evt_beat;
	res_t core_res;
	logic core_res_valid;
	logic core_busy;
	logic room;
	logic evt_take;

	// Intake is throttled only by the space left in the result queue.
	assign evt.ready = room;
	assign evt_take  = evt.valid && room;

	// Event beat as one word for the input stage.
	assign evt_beat.func           = evt.func;
	assign evt_beat.host_connected = evt.host_connected;
	assign evt_beat.profile_index  = evt.profile_index;
	assign evt_beat.is_active      = evt.is_active;
	assign evt_beat.glow_enabled   = evt.glow_enabled;

	// Period registers.
	rss_cfg_regs u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (regs)
	);

	// Input stage, sequencer state and result logic. Animation, blink bursts,
	// link checks and idle handling all resolve while the event sits in the
	// input stage.
	rss_core #(
		.TIMER_BITS       (TIMER_BITS),
		.SUNRISE_FRAMES   (SUNRISE_FRAMES),
		.COLORED_PROFILES (COLORED_PROFILES)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.evt_take  (evt_take),
		.evt       (evt_beat),
		.cfg       (regs),
		.busy      (core_busy),
		.res_valid (core_res_valid),
		.res       (core_res)
	);

	// Result queue: only events that set the LED state push a beat.
	rss_out_fifo u_oq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (core_res_valid),
		.push_data (core_res),
		.reserve   (core_busy),
		.room      (room),
		.res       (res)
	);

endmodule

/* design/rss_checker.sv */
module rss_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       evt_valid,
	input logic       evt_ready,
	input logic       res_valid,
	input logic       res_ready,
	input logic       res_led_on,
	input logic [8:0] res_hue,
	input logic [6:0] res_saturation,
	input logic [6:0] res_brightness
);
	import rss_pkg::*;

	// A result only appears from an empty queue after an event beat has passed the input stage.
	a_result_has_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid) |-> $past(evt_valid && evt_ready, 2))
		else $error("result appeared without a preceding event beat");

	// An off result carries a zero color.
	a_off_is_black: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_led_on |->
			res_hue == '0 && res_saturation == '0 && res_brightness == '0)
		else $error("off result with nonzero color");

	// A shown color stays within its legal ranges.
	a_color_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_led_on |->
			res_hue <= HUE_MAX && res_saturation <= PCT_MAX && res_brightness <= PCT_MAX)
		else $error("shown color out of range");

	// A stalled result beat holds.
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_led_on) && $stable(res_hue)
			&& $stable(res_saturation) && $stable(res_brightness))
		else $error("stalled result changed");

endmodule

bind rgb_status_sequencer rss_checker u_rss_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.evt_valid      (evt.valid),
	.evt_ready      (evt.ready),
	.res_valid      (res.valid),
	.res_ready      (res.ready),
	.res_led_on     (res.led_on),
	.res_hue        (res.hue),
	.res_saturation (res.saturation),
	.res_brightness (res.brightness)
);

/* tb/sv/testbench.sv */
module testbench;
	import rss_pkg::*;

	// A healthy run never goes this long without a beat on some channel: sender gaps
	// and receiver stalls are short random runs, and the longest deliberate pause is
	// the settle wait before a register write.
	localparam int WATCHDOG_LIMIT = 2000;
	// A result passes the input stage and the result queue; this wait gives both
	// ample time to empty before the registers change.
	localparam int SETTLE_CYCLES  = 8;
	// Ticks sent at the largest periods.
	localparam int MAX_PERIOD_TICKS = 30;

	// Expected LED behavior plus the store of LED commands still owed by the block.
	class led_tracker;
		logic [CFG_W-1:0] flash_ms, sunrise_ms, monitor_ms, nohost_ms;
		logic [2:0] act_prof, prev_prof;
		bit linked, idle, glow_saved;
		mode_t mode;
		logic [2:0] steps_left;
		hsb_t burst_col;
		logic [3:0] rise_idx;
		logic [DEF_TIMER_BITS-1:0] anim_t, mon_t, nohost_t;
		bit lit, touched;
		hsb_t col;
		res_t pending[$];
		int errors;

		function void clear();
			flash_ms = RST_FLASH_MS;
			sunrise_ms = RST_SUNRISE_MS;
			monitor_ms = RST_MONITOR_MS;
			nohost_ms = RST_NOHOST_MS;
			act_prof = '0;
			prev_prof = '0;
			linked = 0;
			idle = 0;
			glow_saved = 1;
			mode = MODE_NONE;
			steps_left = '0;
			burst_col = '0;
			rise_idx = '0;
			anim_t = '0;
			mon_t = '0;
			nohost_t = '0;
			lit = 0;
			col = '0;
			pending.delete();
			errors = 0;
		endfunction

		task complain(string msg);
			errors++;
			$display("mismatch: %s", msg);
		endtask

		function void write_reg(reg_idx_t idx, logic [CFG_W-1:0] v);
			case (idx)
				REG_FLASH:   flash_ms = v;
				REG_SUNRISE: sunrise_ms = v;
				REG_MONITOR: monitor_ms = v;
				REG_NOHOST:  nohost_ms = v;
			endcase
		endfunction

		function logic [DEF_TIMER_BITS-1:0] bump(logic [DEF_TIMER_BITS-1:0] t);
			return (&t) ? t : t + 1'b1;
		endfunction

		function bit colored(logic [2:0] p);
			return p < DEF_COLORED_PROFILES;
		endfunction

		// Profiles beyond the colored ones fall back to the warning red.
		function hsb_t tint(logic [2:0] p);
			if (p == 3'd1) return '{9'd120, 7'd100, 7'd25};
			if (p == 3'd2) return '{9'd240, 7'd100, 7'd25};
			return '{9'd0, 7'd100, 7'd25};
		endfunction

		function hsb_t frame(logic [3:0] i);
			case (i)
				4'd0:    return '{9'd300, 7'd100, 7'd20};
				4'd1:    return '{9'd325, 7'd100, 7'd22};
				4'd2:    return '{9'd350, 7'd100, 7'd24};
				4'd3:    return '{9'd12, 7'd100, 7'd25};
				4'd4:    return '{9'd24, 7'd100, 7'd27};
				4'd5:    return '{9'd36, 7'd100, 7'd28};
				4'd6:    return '{9'd48, 7'd90, 7'd30};
				default: return '{9'd24, 7'd55, 7'd25};
			endcase
		endfunction

		function void show(hsb_t c);
			col = c;
			lit = 1;
			touched = 1;
		endfunction

		function void go_dark();
			lit = 0;
			touched = 1;
		endfunction

		function void settle(bit conn);
			if (!idle && conn) show(tint(act_prof));
			else go_dark();
		endfunction

		function void start_burst(hsb_t c, int unsigned n);
			mode = MODE_BLINK;
			burst_col = c;
			steps_left = 3'(2 * n - 1);
			show(c);
			anim_t = '0;
		endfunction

		function void rise_step(bit conn);
			if (rise_idx >= DEF_SUNRISE_FRAMES) begin
				mode = MODE_NONE;
				if (conn) show(tint(act_prof));
				else go_dark();
			end else begin
				show(frame(rise_idx));
				rise_idx++;
				anim_t = '0;
			end
		endfunction

		function void blink_step(bit conn);
			if (steps_left == 0) begin
				mode = MODE_NONE;
				settle(conn);
			end else begin
				if (steps_left[0]) go_dark();
				else show(burst_col);
				steps_left--;
				anim_t = '0;
			end
		endfunction

		function void link_check(bit conn);
			if (idle) return;
			if (conn && !linked) begin
				start_burst(tint(act_prof), 3);
			end else if (!conn && steps_left == 0 && nohost_t >= nohost_ms) begin
				nohost_t = '0;
				start_burst(NOHOST_COLOR, 2);
			end
			linked = conn;
		endfunction

		// Apply one accepted event and queue the LED command it leads to, if any.
		function void take_event(evt_t e);
			logic [CFG_W-1:0] per;
			bit chg;
			touched = 0;
			case (e.func)
				FUNC_TICK: begin
					nohost_t = bump(nohost_t);
					if (mode == MODE_SUNRISE || mode == MODE_BLINK) begin
						per = (mode == MODE_SUNRISE) ? sunrise_ms : flash_ms;
						anim_t = bump(anim_t);
						if (anim_t >= per) begin
							anim_t = '0;
							if (mode == MODE_SUNRISE) rise_step(e.host_connected);
							else blink_step(e.host_connected);
						end
					end
					mon_t = bump(mon_t);
					if (mon_t >= monitor_ms) begin
						mon_t = '0;
						link_check(e.host_connected);
					end
				end
				FUNC_ACTIVITY: begin
					if (e.is_active) begin
						if (idle) begin
							idle = 0;
							nohost_t = '0;
							if (glow_saved) begin
								lit = 1;
								touched = 1;
							end
						end
					end else if (!idle) begin
						glow_saved = e.glow_enabled;
						idle = 1;
						mode = MODE_NONE;
						go_dark();
					end
				end
				FUNC_PROFILE: begin
					chg = e.profile_index != prev_prof;
					act_prof = e.profile_index;
					prev_prof = e.profile_index;
					linked = e.host_connected;
					if (e.host_connected && colored(e.profile_index))
						start_burst(tint(e.profile_index), 3);
					else if (chg && colored(e.profile_index))
						start_burst(tint(e.profile_index), 2);
				end
				FUNC_RECONNECT: begin
					if (rise_idx > 0 && rise_idx <= DEF_SUNRISE_FRAMES)
						show(frame(rise_idx - 1'b1));
					else
						settle(e.host_connected);
				end
				FUNC_INIT: begin
					act_prof = e.profile_index;
					prev_prof = e.profile_index;
					linked = e.host_connected;
					nohost_t = '0;
					mode = MODE_SUNRISE;
					rise_idx = '0;
					anim_t = '0;
					rise_step(e.host_connected);
					mon_t = '0;
				end
				default: ;
			endcase
			if (touched) begin
				pending.push_back(lit ? res_t'{1'b1, col.hue, col.sat, col.bri} : res_t'('0));
			end
		endfunction

		task check_led(res_t got);
			res_t want;
			if (pending.size() == 0) begin
				complain($sformatf("LED beat with nothing owed: on=%0d h=%0d s=%0d b=%0d",
					got.led_on, got.hue, got.saturation, got.brightness));
				return;
			end
			want = pending.pop_front();
			if (got.led_on !== want.led_on)
				complain($sformatf("led_on %0d, want %0d", got.led_on, want.led_on));
			if (got.hue !== want.hue)
				complain($sformatf("hue %0d, want %0d", got.hue, want.hue));
			if (got.saturation !== want.saturation)
				complain($sformatf("saturation %0d, want %0d", got.saturation, want.saturation));
			if (got.brightness !== want.brightness)
				complain($sformatf("brightness %0d, want %0d", got.brightness, want.brightness));
		endtask
	endclass

	logic clk;
	logic arst_n;

	rss_evt_if evt_ch();
	rss_res_if res_ch();
	rss_cfg_if cfg_ch();

	rgb_status_sequencer dut (
		.clk    (clk),
		.arst_n (arst_n),
		.evt    (evt_ch),
		.res    (res_ch),
		.cfg    (cfg_ch)
	);

	led_tracker sb;
	int idle_pct;
	int stall_pct;
	int quiet_cycles;
	bit link_up;

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	// The LED side stalls at random; the percentage drops to zero for the stretch that
	// runs with no idling at all.
	always @(negedge clk) begin
		res_ch.ready <= ($urandom_range(99) >= stall_pct);
	end

	// Everything is observed at the rising edge, from values that were settled since
	// the falling edge. A result is checked before the event of the same edge is
	// noted; an event accepted now cannot own a result that leaves on the same edge.
	always @(posedge clk) begin
		if (res_ch.valid && res_ch.ready)
			sb.check_led('{res_ch.led_on, res_ch.hue, res_ch.saturation, res_ch.brightness});
		if (evt_ch.valid && evt_ch.ready)
			sb.take_event('{evt_ch.func, evt_ch.host_connected, evt_ch.profile_index,
				evt_ch.is_active, evt_ch.glow_enabled});
		if (cfg_ch.valid && cfg_ch.ready)
			sb.write_reg(reg_idx_t'(cfg_ch.index), cfg_ch.data);

		// Watchdog: a block that stops taking or giving beats ends the run here.
		if ((res_ch.valid && res_ch.ready) || (evt_ch.valid && evt_ch.ready) ||
				(cfg_ch.valid && cfg_ch.ready)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("watchdog: no beat for %0d cycles", quiet_cycles);
				$display("TB_ERROR");
				$finish;
			end
		end
	end

	function automatic evt_t make_event(func_t f, bit conn, logic [2:0] prof, bit act,
			bit glow);
		return '{f, conn, prof, act, glow};
	endfunction

	// Mostly millisecond ticks with a slowly changing link, as a real keyboard sees
	// them, with the other events sprinkled in and a few undefined codes as noise.
	function automatic evt_t random_event();
		evt_t e;
		int r;
		r = $urandom_range(99);
		if ($urandom_range(99) < 4) link_up = !link_up;
		e.host_connected = ($urandom_range(99) < 10) ? 1'($urandom_range(1)) : link_up;
		e.profile_index = ($urandom_range(99) < 70) ? 3'($urandom_range(2)) :
			3'($urandom_range(7));
		e.is_active = ($urandom_range(99) < 55);
		e.glow_enabled = 1'($urandom_range(1));
		if (r < 72) e.func = FUNC_TICK;
		else if (r < 80) e.func = FUNC_ACTIVITY;
		else if (r < 87) e.func = FUNC_PROFILE;
		else if (r < 91) e.func = FUNC_RECONNECT;
		else if (r < 96) e.func = FUNC_INIT;
		else e.func = 3'($urandom_range(7, 5));
		return e;
	endfunction

	// Offer one event and hold it until the block takes it. The sender may idle
	// first; valid and payload change only at the falling edge.
	task automatic send_event(evt_t e);
		@(negedge clk);
		while ($urandom_range(99) < idle_pct) begin
			evt_ch.valid <= 1'b0;
			@(negedge clk);
		end
		evt_ch.valid <= 1'b1;
		evt_ch.func <= e.func;
		evt_ch.host_connected <= e.host_connected;
		evt_ch.profile_index <= e.profile_index;
		evt_ch.is_active <= e.is_active;
		evt_ch.glow_enabled <= e.glow_enabled;
		do @(posedge clk); while (!evt_ch.ready);
	endtask

	task automatic run_random(int count);
		repeat (count) send_event(random_event());
	endtask

	// Stop sending and wait for every owed LED beat.
	task automatic wait_results_done();
		@(negedge clk);
		evt_ch.valid <= 1'b0;
		while (sb.pending.size() != 0) @(posedge clk);
	endtask

	// A tick can be in flight with nothing owed, so let the pipeline run dry too.
	task automatic quiesce();
		wait_results_done();
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_regs(logic [CFG_W-1:0] flash, logic [CFG_W-1:0] rise,
			logic [CFG_W-1:0] mon, logic [CFG_W-1:0] nohost);
		reg_idx_t idx[4];
		logic [CFG_W-1:0] val[4];
		idx = '{REG_FLASH, REG_SUNRISE, REG_MONITOR, REG_NOHOST};
		val = '{flash, rise, mon, nohost};
		for (int i = 0; i < 4; i++) begin
			@(negedge clk);
			cfg_ch.valid <= 1'b1;
			cfg_ch.index <= idx[i];
			cfg_ch.data <= val[i];
			do @(posedge clk); while (!cfg_ch.ready);
		end
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	initial begin
		sb = new;
		sb.clear();
		idle_pct = 31;
		stall_pct = 31;
		quiet_cycles = 0;
		link_up = 0;
		arst_n = 1'b0;
		evt_ch.valid = 1'b0;
		evt_ch.func = FUNC_TICK;
		evt_ch.host_connected = 1'b0;
		evt_ch.profile_index = '0;
		evt_ch.is_active = 1'b0;
		evt_ch.glow_enabled = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = REG_FLASH;
		cfg_ch.data = '0;
		res_ch.ready = 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed part at the reset periods. Before any init the reconnect path
		// falls back to the profile color or off.
		send_event(make_event(FUNC_RECONNECT, 0, 3'd0, 0, 0));
		send_event(make_event(FUNC_RECONNECT, 1, 3'd7, 1, 1));
		send_event(make_event(FUNC_TICK, 1, 3'd7, 1, 1));
		// Going idle with the underglow off blanks; a second idle is ignored and
		// waking brings nothing back.
		send_event(make_event(FUNC_ACTIVITY, 0, 3'd0, 0, 0));
		send_event(make_event(FUNC_ACTIVITY, 0, 3'd0, 0, 1));
		send_event(make_event(FUNC_RECONNECT, 1, 3'd0, 0, 0));
		send_event(make_event(FUNC_ACTIVITY, 1, 3'd0, 1, 0));
		// With the underglow on, waking restores the last color.
		send_event(make_event(FUNC_ACTIVITY, 0, 3'd0, 0, 1));
		send_event(make_event(FUNC_ACTIVITY, 1, 3'd0, 1, 0));
		// Profile changes: connected, changed but unlinked, unchanged, and profiles
		// without a color of their own.
		send_event(make_event(FUNC_PROFILE, 1, 3'd1, 0, 0));
		send_event(make_event(FUNC_PROFILE, 0, 3'd2, 0, 0));
		send_event(make_event(FUNC_PROFILE, 0, 3'd2, 1, 1));
		send_event(make_event(FUNC_PROFILE, 1, 3'd5, 0, 0));
		send_event(make_event(FUNC_PROFILE, 0, 3'd7, 0, 0));
		// Inits start the sunrise; a reconnect then repeats the last frame shown.
		send_event(make_event(FUNC_INIT, 0, 3'd7, 0, 0));
		send_event(make_event(FUNC_RECONNECT, 0, 3'd0, 0, 0));
		send_event(make_event(FUNC_INIT, 1, 3'd0, 1, 1));
		send_event(make_event(func_t'(3'd5), 1, 3'd7, 1, 1));
		send_event(make_event(func_t'(3'd7), 0, 3'd0, 0, 0));
		// Idle in the middle of a sunrise, an init while idle, then a wake.
		send_event(make_event(FUNC_ACTIVITY, 1, 3'd0, 0, 1));
		send_event(make_event(FUNC_INIT, 1, 3'd2, 0, 0));
		send_event(make_event(FUNC_ACTIVITY, 0, 3'd0, 1, 0));

		// Shortest periods: every tick steps the animation and checks the link.
		quiesce();
		set_regs(16'd1, 16'd1, 16'd1, 16'd1);
		run_random(140);

		// A long stretch with neither side idling.
		quiesce();
		set_regs(16'd2, 16'd3, 16'd5, 16'd20);
		idle_pct = 0;
		stall_pct = 0;
		run_random(140);
		idle_pct = 31;
		stall_pct = 31;

		// Halfway through, the sender holds off until the block owes nothing.
		quiesce();
		set_regs(16'd3, 16'd2, 16'd4, 16'd40);
		run_random(70);
		wait_results_done();
		run_random(70);

		quiesce();
		set_regs(16'd4, 16'd1, 16'd3, 16'd8);
		run_random(100);

		// Largest periods: no timer gets near them in a short run, so a disconnected
		// keyboard ticking along must stay on the first sunrise frame.
		quiesce();
		set_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		send_event(make_event(FUNC_ACTIVITY, 0, 3'd0, 1, 1));
		send_event(make_event(FUNC_INIT, 0, 3'd0, 0, 0));
		for (int i = 0; i < MAX_PERIOD_TICKS; i++) begin
			send_event(make_event(FUNC_TICK, 0, 3'($urandom_range(7)),
				1'($urandom_range(1)), 1'($urandom_range(1))));
		end
		run_random(20);

		// Back to the power-on periods for a last mixed run.
		quiesce();
		set_regs(RST_FLASH_MS, RST_SUNRISE_MS, RST_MONITOR_MS, RST_NOHOST_MS);
		run_random(60);

		quiesce();
		if (sb.pending.size() != 0)
			sb.complain($sformatf("%0d LED beats never arrived", sb.pending.size()));
		if (sb.errors == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule

/* files.f */
design/rss_pkg.sv
design/rss_if.sv
design/rss_cfg_regs.sv
design/rss_core.sv
design/rss_out_fifo.sv
design/rgb_status_sequencer.sv
design/rss_checker.sv
tb/sv/testbench.sv
